@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/tkps_pkg.sv @@
// Types, constants and helper functions of the timed key press sequencer.
`default_nettype none

package tkps_pkg;

  // Sizing
  localparam int MAX_ENTRIES     = 16;
  localparam int CONCURRENT_KEYS = 3;
  localparam int NUM_KEY_SLOTS   = 3;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Key characters that drive pins
  localparam logic [7:0] KEY_ONE   = 8'h31;
  localparam logic [7:0] KEY_THREE = 8'h33;

  // Press lengths in ticks
  localparam logic [7:0] LEN_PRESS  = 8'd20;
  localparam logic [7:0] LEN_FAST   = 8'd10;
  localparam logic [7:0] LEN_LONG   = 8'd50;
  localparam logic [7:0] LEN_VLONG  = 8'd250;
  localparam logic [7:0] LEN_CLICK  = 8'd10;
  localparam logic [2:0] CLICK_PHASES = 3'd4;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    STYLE_PRESS   = 3'd0,
    STYLE_FAST    = 3'd1,
    STYLE_LONG    = 3'd2,
    STYLE_VLONG   = 3'd3,
    STYLE_HOLD    = 3'd4,
    STYLE_RELEASE = 3'd5,
    STYLE_DOUBLE  = 3'd6,
    STYLE_NONE    = 3'd7
  } style_t;

  typedef struct packed {
    logic [15:0]                   wait_ticks;
    style_t                        style;
    logic [NUM_KEY_SLOTS-1:0][7:0] keys;
  } entry_t;

  typedef struct packed {
    opcode_t opcode;
    entry_t  entry;
    logic    last_entry;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] pin_levels;
    logic       busy_res;
    logic       entry_rejected;
  } res_item_t;

  // Pin mask of the keys of an entry; empty unless the target is zero.
  function automatic logic [2:0] key_mask(input entry_t e, input logic [7:0] target);
    logic [2:0] m;
    logic       go;
    logic [7:0] k;
    m  = '0;
    go = 1'b1;
    for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
      k = e.keys[i];
      if (i >= CONCURRENT_KEYS || k == 8'd0) go = 1'b0;
      if (go && target == 8'd0 && k >= KEY_ONE && k <= KEY_THREE) begin
        m[2'(k - KEY_ONE)] = 1'b1;
      end
    end
    return m;
  endfunction

  // High time of a press style when a key matched.
  function automatic logic [7:0] press_len(input style_t s);
    logic [7:0] len;
    case (s)
      STYLE_PRESS:  len = LEN_PRESS;
      STYLE_FAST:   len = LEN_FAST;
      STYLE_LONG:   len = LEN_LONG;
      STYLE_VLONG:  len = LEN_VLONG;
      STYLE_DOUBLE: len = LEN_CLICK;
      default:      len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tkps_cmd_if.sv @@
// Command channel: sequence entries and ticks.
`default_nettype none

interface tkps_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] wait_ticks;
  logic [2:0]  press_style;
  logic [7:0]  key_code_a;
  logic [7:0]  key_code_b;
  logic [7:0]  key_code_c;
  logic        last_entry;

  modport source (
    output valid, opcode, wait_ticks, press_style,
    output key_code_a, key_code_b, key_code_c, last_entry,
    input  ready
  );
  modport sink (
    input  valid, opcode, wait_ticks, press_style,
    input  key_code_a, key_code_b, key_code_c, last_entry,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tkps_res_if.sv @@
// Result channel: pin levels and status.
`default_nettype none

interface tkps_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] pin_levels;
  logic       busy_res;
  logic       entry_rejected;

  modport source (
    output valid, pin_levels, busy_res, entry_rejected,
    input  ready
  );
  modport sink (
    input  valid, pin_levels, busy_res, entry_rejected,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tkps_in_stage.sv @@
// Input register stage of the sequencer.
`default_nettype none

module tkps_in_stage
  import tkps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tkps_cmd_if.sink   cmd,
  input  wire logic  advance,
  output cmd_item_t  item,
  output logic       item_valid
);

  logic      valid;
  cmd_item_t held;

  // Take a new transaction when empty or when the held one moves on
  assign cmd.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ready) begin
      valid <= cmd.valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      held.opcode           <= opcode_t'(cmd.opcode);
      held.entry.wait_ticks <= cmd.wait_ticks;
      held.entry.style      <= style_t'(cmd.press_style);
      held.entry.keys[0]    <= cmd.key_code_a;
      held.entry.keys[1]    <= cmd.key_code_b;
      held.entry.keys[2]    <= cmd.key_code_c;
      held.last_entry       <= cmd.last_entry;
    end
  end

  assign item       = held;
  assign item_valid = valid;

endmodule

`default_nettype wire

@@ hw/rtl/tkps_engine.sv @@
// Sequencer state, entry store and per-transaction update logic.
`default_nettype none

`include "assert_macros.svh"

module tkps_engine
  import tkps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire cmd_item_t  item,
  input  wire logic       fire,
  output res_item_t       result
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  entry_t           store [MAX_ENTRIES];
  logic [7:0]       target_unit;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] load_index, load_index_next;
  logic [CNT_W-1:0] play_index, play_index_next;
  logic [15:0]      wait_counter, wait_counter_next;
  logic             press_active, press_active_next;
  logic [7:0]       press_counter, press_counter_next;
  logic [7:0]       press_length, press_length_next;
  logic [2:0]       click_phase, click_phase_next;
  logic [2:0]       pin_register, pin_register_next;
  logic             store_we;
  logic             rejected;
  logic             done;
  entry_t           cur;
  logic [2:0]       mask;

  // Read the entry being played
  assign cur  = store[play_index[ADDR_W-1:0]];
  assign mask = key_mask(cur, target_unit);

  // Compute the next state for one transaction
  always_comb begin
    entry_count_next   = entry_count;
    load_index_next    = load_index;
    play_index_next    = play_index;
    wait_counter_next  = wait_counter;
    press_active_next  = press_active;
    press_counter_next = press_counter;
    press_length_next  = press_length;
    click_phase_next   = click_phase;
    pin_register_next  = pin_register;
    store_we           = 1'b0;
    rejected           = 1'b0;
    done               = 1'b1;
    if (fire) begin
      if (item.opcode == OP_APPEND) begin
        if (entry_count != '0 || load_index >= MAX_CNT) begin
          rejected = 1'b1;
        end else begin
          store_we        = 1'b1;
          load_index_next = load_index + 1'b1;
          if (item.last_entry) begin
            entry_count_next   = load_index + 1'b1;
            play_index_next    = '0;
            wait_counter_next  = '0;
            press_active_next  = 1'b0;
            press_counter_next = '0;
            press_length_next  = '0;
            click_phase_next   = '0;
          end
        end
      end else if (entry_count != '0) begin
        if (play_index >= entry_count || play_index >= MAX_CNT) begin
          // Sequence complete
          entry_count_next = '0;
          load_index_next  = '0;
          play_index_next  = '0;
        end else if (press_active) begin
          if (press_counter >= press_length) begin
            press_counter_next = '0;
            if (cur.style == STYLE_PRESS || cur.style == STYLE_FAST ||
                cur.style == STYLE_LONG || cur.style == STYLE_VLONG) begin
              pin_register_next = pin_register & ~mask;
            end else if (cur.style == STYLE_DOUBLE && click_phase < CLICK_PHASES &&
                         mask != '0) begin
              pin_register_next = click_phase[0] ? (pin_register & ~mask)
                                                 : (pin_register | mask);
              done = 1'b0;
            end
            if (done) begin
              press_active_next = 1'b0;
              wait_counter_next = '0;
              play_index_next   = play_index + 1'b1;
            end else begin
              click_phase_next = click_phase + 3'd1;
            end
          end else begin
            press_counter_next = press_counter + 8'd1;
          end
        end else if (wait_counter >= cur.wait_ticks) begin
          // Start the press
          case (cur.style)
            STYLE_RELEASE: pin_register_next = pin_register & ~mask;
            STYLE_NONE:    pin_register_next = pin_register;
            default:       pin_register_next = pin_register | mask;
          endcase
          press_length_next  = (mask != '0) ? press_len(cur.style) : 8'd0;
          wait_counter_next  = '0;
          press_counter_next = '0;
          press_active_next  = 1'b1;
          click_phase_next   = (cur.style == STYLE_DOUBLE) ? 3'd1 : 3'd0;
        end else begin
          wait_counter_next = wait_counter + 16'd1;
        end
      end
    end
  end

  // Drive the result of this transaction
  always_comb begin
    result.pin_levels     = pin_register_next;
    result.busy_res       = (entry_count_next != '0);
    result.entry_rejected = rejected;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      load_index    <= '0;
      play_index    <= '0;
      wait_counter  <= '0;
      press_active  <= 1'b0;
      press_counter <= '0;
      press_length  <= '0;
      click_phase   <= '0;
      pin_register  <= '0;
    end else begin
      entry_count   <= entry_count_next;
      load_index    <= load_index_next;
      play_index    <= play_index_next;
      wait_counter  <= wait_counter_next;
      press_active  <= press_active_next;
      press_counter <= press_counter_next;
      press_length  <= press_length_next;
      click_phase   <= click_phase_next;
      pin_register  <= pin_register_next;
    end
  end

  // Target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_unit <= '0;
    end else if (cfg_we) begin
      target_unit <= cfg_wdata;
    end
  end

  // Write appended entries
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[load_index[ADDR_W-1:0]] <= item.entry;
    end
  end

  `ASSERT_NEXT(a_armed_load_hold, clk, rst, fire && item.opcode == OP_APPEND && entry_count != '0, $stable(load_index))
  `ASSERT_IMPL(a_count_matches_load, clk, rst, entry_count != '0, load_index == entry_count)
  `ASSERT_NEXT(a_idle_pins_hold, clk, rst, fire && item.opcode == OP_TICK && entry_count == '0, $stable(pin_register))

endmodule

`default_nettype wire

@@ hw/rtl/tkps_out_stage.sv @@
// Result register stage of the sequencer.
`default_nettype none

module tkps_out_stage
  import tkps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire res_item_t result,
  tkps_res_if.source     res,
  output logic           advance
);

  logic      valid;
  res_item_t held;

  // Load when empty or when the consumer takes the held result
  assign advance = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held <= result;
    end
  end

  assign res.valid          = valid;
  assign res.pin_levels     = held.pin_levels;
  assign res.busy_res       = held.busy_res;
  assign res.entry_rejected = held.entry_rejected;

endmodule

`default_nettype wire

@@ hw/rtl/timed_key_press_sequencer_core.sv @@
// Top level of the timed key press sequencer.
`default_nettype none

// Each command transaction (append an entry or advance one tick) yields one
// result transaction with the relay pin levels, the busy flag and the reject
// flag. A transaction is accepted every cycle while the result side keeps up.
// The command is registered in the input register, and the single-pass update
// loads its result into the result register, which drives res. A result that
// waits in the result register holds the command behind it in the input
// register. The entry store is a register file of MAX_ENTRIES entries read at
// the play index, with no clearing pass after reset. The target register is
// written through cfg_we/cfg_wdata and applies to ticks processed after the
// write.
module timed_key_press_sequencer_core
  import tkps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tkps_cmd_if.sink        cmd,
  tkps_res_if.source      res
);

  cmd_item_t item;
  logic      item_valid;
  logic      advance;
  logic      fire;
  res_item_t result;

  // Process the held command when the result register can take its result
  assign fire = item_valid && advance;

  tkps_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  tkps_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .fire      (fire),
    .result    (result)
  );

  tkps_out_stage u_out_stage (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .result  (result),
    .res     (res),
    .advance (advance)
  );

endmodule

`default_nettype wire

@@ dv/tkps_sequence_checker.sv @@
// Sequencer checker: predicts each result from command and config traffic and compares it.
`timescale 1ns / 100ps

module tkps_sequence_checker
  import tkps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  tkps_cmd_if        cmd,
  tkps_res_if        res,
  output int         mismatches,
  output int         results_due
);

  typedef struct packed {
    logic [15:0] wait_ticks;
    style_t      style;
    logic [7:0]  key_a;
    logic [7:0]  key_b;
    logic [7:0]  key_c;
  } seq_step_t;

  // Predicted sequencer state
  seq_step_t        steps [MAX_ENTRIES];
  logic [CNT_W-1:0] armed_len;
  logic [CNT_W-1:0] fill_idx;
  logic [CNT_W-1:0] play_idx;
  logic [15:0]      wait_cnt;
  logic             pressing;
  logic [7:0]       press_cnt;
  logic [7:0]       press_len;
  logic [2:0]       click_ph;
  logic [2:0]       pins;
  logic [7:0]       target;

  // Pin reports predicted but not yet seen on the result channel
  res_item_t pin_reports [$];

  // Map the key list of a step to pin bits; a zero key ends the list.
  function automatic logic [2:0] pins_of_keys(input seq_step_t s);
    logic [2:0] m;
    logic       more;
    logic [7:0] k;
    logic [1:0] bit_idx;
    m    = '0;
    more = 1'b1;
    for (int i = 0; i < CONCURRENT_KEYS; i++) begin
      k = (i == 0) ? s.key_a : (i == 1) ? s.key_b : s.key_c;
      if (k == 8'd0) more = 1'b0;
      if (more && target == 8'd0 && k >= KEY_ONE && k <= KEY_THREE) begin
        bit_idx = k[1:0] - 2'd1;
        m[bit_idx] = 1'b1;
      end
    end
    return m;
  endfunction

  // Advance the armed sequence by one tick.
  task automatic advance_tick();
    seq_step_t  s;
    logic [2:0] m;
    if (armed_len == '0) return;
    if (play_idx >= armed_len || play_idx >= MAX_ENTRIES) begin
      armed_len = '0;
      fill_idx  = '0;
      play_idx  = '0;
      return;
    end
    s = steps[play_idx[ADDR_W-1:0]];
    m = pins_of_keys(s);
    if (pressing) begin
      if (press_cnt >= press_len) begin
        press_cnt = '0;
        if (s.style == STYLE_DOUBLE && m != '0 && click_ph < CLICK_PHASES) begin
          // toggle the clicked pins and stay on this step
          if (!click_ph[0]) pins = pins | m;
          else pins = pins & ~m;
          click_ph = click_ph + 3'd1;
        end else begin
          if (s.style <= STYLE_VLONG) pins = pins & ~m;
          pressing = 1'b0;
          wait_cnt = '0;
          play_idx = play_idx + 1'b1;
        end
      end else begin
        press_cnt = press_cnt + 8'd1;
      end
    end else if (wait_cnt >= s.wait_ticks) begin
      // start the press
      press_len = 8'd0;
      if (m != '0) begin
        case (s.style)
          STYLE_PRESS:   begin pins = pins | m; press_len = LEN_PRESS; end
          STYLE_FAST:    begin pins = pins | m; press_len = LEN_FAST; end
          STYLE_LONG:    begin pins = pins | m; press_len = LEN_LONG; end
          STYLE_VLONG:   begin pins = pins | m; press_len = LEN_VLONG; end
          STYLE_HOLD:    pins = pins | m;
          STYLE_RELEASE: pins = pins & ~m;
          STYLE_DOUBLE:  begin pins = pins | m; press_len = LEN_CLICK; end
          default:       ;
        endcase
      end
      wait_cnt  = '0;
      press_cnt = '0;
      pressing  = 1'b1;
      click_ph  = (s.style == STYLE_DOUBLE) ? 3'd1 : 3'd0;
    end else begin
      wait_cnt = wait_cnt + 16'd1;
    end
  endtask

  // Store an appended step unless the sequence is armed or the store is full.
  task automatic take_entry(output logic refused);
    refused = 1'b0;
    if (armed_len != '0 || fill_idx >= MAX_ENTRIES) begin
      refused = 1'b1;
    end else begin
      steps[fill_idx[ADDR_W-1:0]] = '{wait_ticks: cmd.wait_ticks,
                                      style: style_t'(cmd.press_style),
                                      key_a: cmd.key_code_a, key_b: cmd.key_code_b,
                                      key_c: cmd.key_code_c};
      fill_idx = fill_idx + 1'b1;
      if (cmd.last_entry) begin
        armed_len = fill_idx;
        play_idx  = '0;
        wait_cnt  = '0;
        pressing  = 1'b0;
        press_cnt = '0;
        press_len = '0;
        click_ph  = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare accepted results, then predict for accepted commands.
  always @(posedge clk) begin
    res_item_t want;
    logic      refused;
    if (rst) begin
      mismatches = 0;
      target    = '0;
      armed_len = '0;
      fill_idx  = '0;
      play_idx  = '0;
      wait_cnt  = '0;
      pressing  = 1'b0;
      press_cnt = '0;
      press_len = '0;
      click_ph  = '0;
      pins      = '0;
      pin_reports.delete();
    end else begin
      if (cfg_we) target = cfg_wdata;
      if (res.valid && res.ready) begin
        if (pin_reports.size() == 0) begin
          $display("%0t: unexpected result, pins %0d busy %0d rejected %0d", $time,
                   res.pin_levels, res.busy_res, res.entry_rejected);
          mismatches++;
        end else begin
          want = pin_reports.pop_front();
          check_field("pin_levels", want.pin_levels, res.pin_levels);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("entry_rejected", want.entry_rejected, res.entry_rejected);
        end
      end
      if (cmd.valid && cmd.ready) begin
        refused = 1'b0;
        if (opcode_t'(cmd.opcode) == OP_TICK) advance_tick();
        else take_entry(refused);
        pin_reports.push_back('{pin_levels: pins, busy_res: (armed_len != '0),
                                entry_rejected: refused});
      end
    end
    results_due <= pin_reports.size();
  end

endmodule

@@ dv/tb_timed_key_press_sequencer_core.sv @@
// Testbench top: drives sequences, ticks and target writes into the sequencer and gives the verdict.
`timescale 1ns / 100ps

module tb_timed_key_press_sequencer_core
  import tkps_pkg::*;
();

  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         PHASE_ITEMS  = 40;
  localparam logic [7:0] KEY_TWO      = KEY_ONE + 8'd1;

  typedef struct packed {
    logic [15:0] w;
    style_t      st;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
  } step_plan_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         mismatches;
  int         results_due;

  int         burst_left   = 0;
  int         sent_items   = 0;
  int         stall_mode   = 0;
  int         mode_left    = 0;
  int         stall_phase  = 0;
  int         quiet_cycles = 0;
  step_plan_t plan [$];

  tkps_cmd_if cmd_ch ();
  tkps_res_if res_ch ();

  timed_key_press_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  tkps_sequence_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always #1 clk = ~clk;

  // Stall the result side: switch between always ready, coin flips and one-in-four.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 160);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
      default: res_ch.ready <= (stall_phase % 4 == 0);
    endcase
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[timed_key_press_sequencer_core] ERROR");
      $finish;
    end
  end

  // Send one command transaction, opening a new burst after a random gap.
  task automatic send_cmd(input opcode_t op, input step_plan_t s, input logic last);
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= op;
    cmd_ch.wait_ticks  <= s.w;
    cmd_ch.press_style <= s.st;
    cmd_ch.key_code_a  <= s.a;
    cmd_ch.key_code_b  <= s.b;
    cmd_ch.key_code_c  <= s.c;
    cmd_ch.last_entry  <= last;
    do @(posedge clk); while (!cmd_ch.ready);
    burst_left--;
    sent_items++;
  endtask

  function automatic step_plan_t any_step();
    return '{w: 16'($urandom), st: style_t'($urandom_range(0, 7)), a: 8'($urandom),
             b: 8'($urandom), c: 8'($urandom)};
  endfunction

  // Tick with a random payload, which the block must ignore.
  task automatic send_tick();
    send_cmd(OP_TICK, any_step(), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return KEY_ONE + 8'($urandom_range(0, 2));
      6:                return 8'h00;
      7:                return KEY_ONE - 8'd1;
      8:                return KEY_THREE + 8'd1;
      default:          return 8'($urandom);
    endcase
  endfunction

  // Hold the sender until every result is back and the pipeline is empty.
  task automatic quiesce();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_target(input logic [7:0] t);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Load the planned steps, arm on the last one, then tick until the sequence
  // is surely done. Appends while armed must be refused.
  task automatic load_and_run(input bit poke);
    int budget;
    int floor_ticks;
    budget      = 1;
    floor_ticks = 0;
    foreach (plan[i]) begin
      budget      += plan[i].w + 1;
      floor_ticks += plan[i].w + 2;
      case (plan[i].st)
        STYLE_PRESS:  budget += LEN_PRESS + 1;
        STYLE_FAST:   budget += LEN_FAST + 1;
        STYLE_LONG:   budget += LEN_LONG + 1;
        STYLE_VLONG:  budget += LEN_VLONG + 1;
        STYLE_DOUBLE: budget += 4 * (LEN_CLICK + 1);
        default:      budget += 1;
      endcase
      // a tick before arming changes nothing
      if ($urandom_range(0, 9) == 0) send_tick();
      send_cmd(OP_APPEND, plan[i], i == plan.size() - 1);
    end
    if (poke) begin
      send_cmd(OP_APPEND, '{w: 16'hFFFF, st: STYLE_NONE, a: 8'hFF, b: 8'hFF, c: 8'hFF}, 1'b1);
    end
    for (int t = 0; t < budget; t++) begin
      // stay inside the shortest possible run so the append is surely refused
      if (t < floor_ticks && $urandom_range(0, 7) == 0) begin
        send_cmd(OP_APPEND, any_step(), 1'($urandom_range(0, 1)));
      end
      send_tick();
    end
    plan.delete();
  endtask

  initial begin
    logic [7:0] targets [5];
    step_plan_t s;
    int         phase_end;
    int         n;

    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= OP_TICK;
    cmd_ch.wait_ticks  <= '0;
    cmd_ch.press_style <= STYLE_NONE;
    cmd_ch.key_code_a  <= '0;
    cmd_ch.key_code_b  <= '0;
    cmd_ch.key_code_c  <= '0;
    cmd_ch.last_entry  <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    rst                <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every style, key list ends, unmatched keys, append while armed
    set_target(8'h00);
    plan.push_back('{w: 16'd0, st: STYLE_PRESS,   a: KEY_ONE,   b: 8'h00,    c: KEY_THREE});
    plan.push_back('{w: 16'd1, st: STYLE_FAST,    a: KEY_TWO,   b: KEY_THREE, c: 8'h00});
    plan.push_back('{w: 16'd2, st: STYLE_DOUBLE,  a: KEY_THREE, b: KEY_ONE,  c: KEY_TWO});
    plan.push_back('{w: 16'd0, st: STYLE_HOLD,    a: KEY_ONE,   b: KEY_TWO,  c: 8'h00});
    plan.push_back('{w: 16'd3, st: STYLE_RELEASE, a: 8'hFF,     b: KEY_ONE,  c: 8'h00});
    plan.push_back('{w: 16'd0, st: STYLE_NONE,    a: KEY_THREE, b: 8'h00,    c: 8'h00});
    plan.push_back('{w: 16'd0, st: STYLE_LONG,    a: 8'h34,     b: 8'h30,    c: 8'h00});
    plan.push_back('{w: 16'd0, st: STYLE_DOUBLE,  a: 8'h30,     b: 8'h00,    c: 8'h00});
    plan.push_back('{w: 16'd0, st: STYLE_VLONG,   a: KEY_TWO,   b: 8'h00,    c: 8'h00});
    load_and_run(1'b1);

    // Nonzero target: keys must not reach the pins
    set_target(8'hFF);
    plan.push_back('{w: 16'd0, st: STYLE_PRESS,  a: KEY_ONE, b: 8'h00, c: 8'h00});
    plan.push_back('{w: 16'd1, st: STYLE_DOUBLE, a: KEY_TWO, b: 8'h00, c: 8'h00});
    load_and_run(1'b0);

    // Random sequences under several targets
    targets = '{8'hFF, 8'h00, 8'h01, 8'($urandom_range(2, 254)), 8'h00};
    foreach (targets[p]) begin
      set_target(targets[p]);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_ENTRIES) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          s.w  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 60))
                                             : 16'($urandom_range(0, 4));
          s.st = style_t'($urandom_range(0, 7));
          if (s.st == STYLE_VLONG && $urandom_range(0, 3) != 0) s.st = STYLE_FAST;
          s.a  = pick_key();
          s.b  = pick_key();
          s.c  = pick_key();
          plan.push_back(s);
        end
        load_and_run(1'b0);
      end
    end

    // Fill the store without arming; nothing frees it afterwards, so this runs last
    set_target(8'h00);
    s = '{w: 16'd0, st: STYLE_PRESS, a: KEY_ONE, b: 8'h00, c: 8'h00};
    repeat (MAX_ENTRIES) send_cmd(OP_APPEND, s, 1'b0);
    send_cmd(OP_APPEND, s, 1'b1);
    repeat (4) send_tick();

    quiesce();
    if (mismatches == 0) begin
      $display("[timed_key_press_sequencer_core] OK");
    end else begin
      $display("[timed_key_press_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tkps_pkg.sv
hw/rtl/tkps_cmd_if.sv
hw/rtl/tkps_res_if.sv
hw/rtl/tkps_in_stage.sv
hw/rtl/tkps_engine.sv
hw/rtl/tkps_out_stage.sv
hw/rtl/timed_key_press_sequencer_core.sv
dv/tkps_sequence_checker.sv
dv/tb_timed_key_press_sequencer_core.sv
